// ===== design/sbc_pkg.sv =====
// Shared types and constants for the segment/box clipper.
// No dependencies; imported by sbc_cross and segment_box_clipper.
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

  localparam int CW        = 32;         // coordinate width, signed Q16.16
  localparam int CROSS_LAT = CW + 3;     // prep, multiply, CW divide steps, fixup
  localparam int PIPE_LAT  = CROSS_LAT + 2;  // input reg + crossing + output reg

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic   valid;
    logic   ok;      // crossing exists and lies on the edge span
    coord_t q;       // crossing coordinate on the other axis
  } cross_t;

endpackage
`default_nettype wire

// ===== design/sbc_cross.sv =====
// Pipelined edge crossing unit: one edge, one word per cycle.
// Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbc_cross
  import sbc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire coord_t c,
  input  wire coord_t p1,
  input  wire coord_t q1,
  input  wire coord_t p2,
  input  wire coord_t q2,
  input  wire coord_t lo,
  input  wire coord_t hi,
  input  wire logic   collapsed,
  output cross_t      res
);

  // q = q1 + (c-p1)*(q1-q2)/(p1-p2), the fraction folded back in at the end
  // so the result is the truncated quotient of the full wide numerator.
  logic signed [CW:0] d, e, f;
  logic               span;
  always_comb begin
    d    = {p1[CW-1], p1} - {p2[CW-1], p2};
    e    = {c[CW-1], c} - {p1[CW-1], p1};
    f    = {q1[CW-1], q1} - {q2[CW-1], q2};
    span = (p1 <= c && p2 >= c) || (p1 >= c && p2 <= c);
  end

  // stage: magnitudes
  logic          s1_v, s1_en, s1_neg;
  logic [CW-1:0] s1_a, s1_b, s1_dm;
  coord_t        s1_q1;
  logic signed [CW:0] ea, fa, da;
  always_comb begin
    ea = e[CW] ? -e : e;
    fa = f[CW] ? -f : f;
    da = d[CW] ? -d : d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
    end
    s1_en  <= !collapsed && (d != '0) && span;
    s1_neg <= e[CW] ^ f[CW] ^ d[CW];
    s1_a   <= ea[CW-1:0];
    s1_b   <= fa[CW-1:0];
    s1_dm  <= da[CW-1:0];
    s1_q1  <= q1;
  end

  // stage 0 of the divider holds the product; CW restoring steps follow
  logic          st_v   [0:CW];
  logic          st_en  [0:CW];
  logic          st_neg [0:CW];
  logic [CW-1:0] st_rem [0:CW];
  logic [CW-1:0] st_low [0:CW];
  logic [CW-1:0] st_quo [0:CW];
  logic [CW-1:0] st_dm  [0:CW];
  coord_t        st_q1  [0:CW];

  logic [2*CW-1:0] prod;
  assign prod = s1_a * s1_b;

  logic [CW:0]   trial [0:CW-1];
  logic [CW:0]   diff  [0:CW-1];
  logic          ge    [0:CW-1];
  always_comb begin
    for (int k = 0; k < CW; k++) begin
      trial[k] = {st_rem[k], st_low[k][CW-1]};
      ge[k]    = trial[k] >= {1'b0, st_dm[k]};
      diff[k]  = trial[k] - {1'b0, st_dm[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CW; k++) st_v[k] <= 1'b0;
    end else begin
      st_v[0] <= s1_v;
      for (int k = 0; k < CW; k++) st_v[k+1] <= st_v[k];
    end
    st_en[0]  <= s1_en;
    st_neg[0] <= s1_neg;
    st_rem[0] <= prod[2*CW-1:CW];
    st_low[0] <= prod[CW-1:0];
    st_quo[0] <= '0;
    st_dm[0]  <= s1_dm;
    st_q1[0]  <= s1_q1;
    for (int k = 0; k < CW; k++) begin
      st_en[k+1]  <= st_en[k];
      st_neg[k+1] <= st_neg[k];
      st_rem[k+1] <= ge[k] ? diff[k][CW-1:0] : trial[k][CW-1:0];
      st_low[k+1] <= {st_low[k][CW-2:0], 1'b0};
      st_quo[k+1] <= {st_quo[k][CW-2:0], ge[k]};
      st_dm[k+1]  <= st_dm[k];
      st_q1[k+1]  <= st_q1[k];
    end
  end

  // fixup: add to q1, then step toward zero past a nonzero fraction
  logic signed [CW+1:0] tq, ts, sum, adj;
  logic                 rem_nz;
  coord_t               qv;
  always_comb begin
    tq     = {2'b00, st_quo[CW]};
    ts     = st_neg[CW] ? -tq : tq;
    sum    = {{2{st_q1[CW][CW-1]}}, st_q1[CW]} + ts;
    rem_nz = st_rem[CW] != '0;
    adj    = sum;
    if (rem_nz && st_neg[CW] && sum > 0) adj = sum - 1;
    if (rem_nz && !st_neg[CW] && sum < 0) adj = sum + 1;
    qv     = adj[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= st_v[CW];
    end
    res.ok <= st_en[CW] && qv >= lo && qv <= hi;
    res.q  <= qv;
  end

endmodule
`default_nettype wire

// ===== design/segment_box_clipper.sv =====
// Top level of the segment/box clipper: config registers, input stage,
// four sbc_cross edge units, coordinate delay line and result selection.
// Depends on sbc_pkg and sbc_cross.
//
// Usage:
//   Box edges (signed Q16.16) are written through cfg_wr/cfg_addr/cfg_data,
//   index 0..3 = left, right, bottom, top; write only while no word is in
//   flight. Segments enter on start while busy is low; busy is high only
//   during reset, so one segment word is taken every cycle.
//   Each result word appears for one cycle with done high: hit and the
//   clipped endpoints, all zero on a miss.
// Order: a word passes the input register, the crossing units and the output
//   register, which raises done. Throughput: one word per cycle. The pipeline
//   depth is set by the restoring divider in each crossing unit: one product
//   stage, then one quotient bit per stage.
// Reset: synchronous rst clears all valid bits and the box to zeros.
//   The receiver cannot stall; results are never held or repeated.
`timescale 1ns / 1ps
`default_nettype none
module segment_box_clipper
  import sbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic         start,
  output logic              busy,
  input  wire coord_t       seg_x1,
  input  wire coord_t       seg_y1,
  input  wire coord_t       seg_x2,
  input  wire coord_t       seg_y2,
  output logic              done,
  output logic              hit,
  output coord_t            clip_x1,
  output coord_t            clip_y1,
  output coord_t            clip_x2,
  output coord_t            clip_y2
);

  // box registers
  coord_t box_l, box_r, box_b, box_t;
  always_ff @(posedge clk) begin
    if (rst) begin
      box_l <= '0;
      box_r <= '0;
      box_b <= '0;
      box_t <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_addr))
        REG_LEFT:   box_l <= cfg_data;
        REG_RIGHT:  box_r <= cfg_data;
        REG_BOTTOM: box_b <= cfg_data;
        REG_TOP:    box_t <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign busy = rst;

  // input stage
  logic   a_v;
  coord_t a_x1, a_y1, a_x2, a_y2;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
    end
    a_x1 <= seg_x1;
    a_y1 <= seg_y1;
    a_x2 <= seg_x2;
    a_y2 <= seg_y2;
  end

  // edge crossings: top/bottom run along x, right/left along y
  cross_t c_top, c_rgt, c_bot, c_lft;
  logic   lr_flat, bt_flat;
  assign lr_flat = box_l == box_r;
  assign bt_flat = box_t == box_b;

  sbc_cross u_top (.clk, .rst, .in_valid(a_v), .c(box_t), .p1(a_y1), .q1(a_x1),
                   .p2(a_y2), .q2(a_x2), .lo(box_l), .hi(box_r),
                   .collapsed(lr_flat), .res(c_top));
  sbc_cross u_rgt (.clk, .rst, .in_valid(a_v), .c(box_r), .p1(a_x1), .q1(a_y1),
                   .p2(a_x2), .q2(a_y2), .lo(box_b), .hi(box_t),
                   .collapsed(bt_flat), .res(c_rgt));
  sbc_cross u_bot (.clk, .rst, .in_valid(a_v), .c(box_b), .p1(a_y1), .q1(a_x1),
                   .p2(a_y2), .q2(a_x2), .lo(box_l), .hi(box_r),
                   .collapsed(lr_flat), .res(c_bot));
  sbc_cross u_lft (.clk, .rst, .in_valid(a_v), .c(box_l), .p1(a_x1), .q1(a_y1),
                   .p2(a_x2), .q2(a_y2), .lo(box_b), .hi(box_t),
                   .collapsed(bt_flat), .res(c_lft));

  // endpoints ride alongside the crossing units
  coord_t dl_x1 [0:CROSS_LAT-1];
  coord_t dl_y1 [0:CROSS_LAT-1];
  coord_t dl_x2 [0:CROSS_LAT-1];
  coord_t dl_y2 [0:CROSS_LAT-1];
  always_ff @(posedge clk) begin
    dl_x1[0] <= a_x1;
    dl_y1[0] <= a_y1;
    dl_x2[0] <= a_x2;
    dl_y2[0] <= a_y2;
    for (int k = 1; k < CROSS_LAT; k++) begin
      dl_x1[k] <= dl_x1[k-1];
      dl_y1[k] <= dl_y1[k-1];
      dl_x2[k] <= dl_x2[k-1];
      dl_y2[k] <= dl_y2[k-1];
    end
  end

  function automatic logic in_box(coord_t x, coord_t y, coord_t l, coord_t r,
                                  coord_t b, coord_t t);
    return x >= l && x <= r && y >= b && y <= t;
  endfunction

  // result selection
  coord_t x1, y1, x2, y2;
  logic   f_valid, f_hit, in1, in2, reject, first, second;
  coord_t r0, r1, r2, r3, lo_v, hi_v;
  coord_t px [0:3];
  coord_t py [0:3];
  logic   on [0:3];
  logic [2:0] n;

  assign x1 = dl_x1[CROSS_LAT-1];
  assign y1 = dl_y1[CROSS_LAT-1];
  assign x2 = dl_x2[CROSS_LAT-1];
  assign y2 = dl_y2[CROSS_LAT-1];
  assign f_valid = c_top.valid & c_rgt.valid & c_bot.valid & c_lft.valid;

  always_comb begin
    in1 = in_box(x1, y1, box_l, box_r, box_b, box_t);
    in2 = in_box(x2, y2, box_l, box_r, box_b, box_t);
    n   = 3'(c_top.ok) + 3'(c_rgt.ok) + 3'(c_bot.ok) + 3'(c_lft.ok);
    r0 = '0; r1 = '0; r2 = '0; r3 = '0;
    f_hit  = 1'b0;
    reject = 1'b0;
    first  = 1'b0;
    second = 1'b0;
    lo_v   = '0;
    hi_v   = '0;
    px[0] = c_top.q; py[0] = box_t;   on[0] = c_top.ok;
    px[1] = c_bot.q; py[1] = box_b;   on[1] = c_bot.ok;
    px[2] = box_r;   py[2] = c_rgt.q; on[2] = c_rgt.ok;
    px[3] = box_l;   py[3] = c_lft.q; on[3] = c_lft.ok;
    if (y1 == y2 && y1 == box_b) begin
      // lies on the bottom edge: clip along it
      if (!((x1 <= box_l && x2 <= box_l) || (x1 >= box_r && x2 >= box_r))) begin
        lo_v  = (x1 <= x2) ? x1 : x2;
        hi_v  = (x1 <= x2) ? x2 : x1;
        r0    = (lo_v >= box_l) ? lo_v : box_l;
        r1    = y1;
        r2    = (hi_v <= box_r) ? hi_v : box_r;
        r3    = y1;
        f_hit = 1'b1;
      end
    end else if (y1 == y2 && y1 == box_t) begin
      f_hit = 1'b0;  // top edge belongs to the neighbor
    end else if (x1 == x2 && x1 == box_l) begin
      if (!((y1 <= box_b && y2 <= box_b) || (y1 >= box_t && y2 >= box_t))) begin
        lo_v  = (y1 <= y2) ? y1 : y2;
        hi_v  = (y1 <= y2) ? y2 : y1;
        r0    = x1;
        r1    = (lo_v >= box_b) ? lo_v : box_b;
        r2    = x1;
        r3    = (hi_v <= box_t) ? hi_v : box_t;
        f_hit = 1'b1;
      end
    end else if (x1 == x2 && x1 == box_r) begin
      f_hit = 1'b0;  // right edge belongs to the neighbor
    end else if (n == 3'd0) begin
      if (in1) begin
        r0 = x1; r1 = y1; r2 = x2; r3 = y2;
        f_hit = 1'b1;
      end
    end else if (n == 3'd1) begin
      if (in1) begin
        r0 = x1; r1 = y1;
      end else begin
        r0 = x2; r1 = y2;
      end
      if (c_top.ok) begin
        r2 = c_top.q; r3 = box_t;
      end else if (c_rgt.ok) begin
        r2 = box_r; r3 = c_rgt.q;
      end else if (c_bot.ok) begin
        r2 = c_bot.q; r3 = box_b;
      end else begin
        r2 = box_l; r3 = c_lft.q;
      end
      f_hit = 1'b1;
    end else begin
      // corner touched from outside only
      if (n == 3'd2) begin
        reject =
          (c_top.ok && c_rgt.ok &&
           ((x1 == box_r && y1 == box_t && !in2) || (x2 == box_r && y2 == box_t && !in1))) ||
          (c_top.ok && c_lft.ok &&
           ((x1 == box_l && y1 == box_t && !in2) || (x2 == box_l && y2 == box_t && !in1))) ||
          (c_bot.ok && c_rgt.ok &&
           ((x1 == box_r && y1 == box_b && !in2) || (x2 == box_r && y2 == box_b && !in1))) ||
          (c_bot.ok && c_lft.ok &&
           ((x1 == box_l && y1 == box_b && !in2) || (x2 == box_l && y2 == box_b && !in1)));
      end
      if (!reject) begin
        // first crossing, then the next one at a different point
        for (int k = 0; k < 4; k++) begin
          if (on[k] && !second) begin
            if (!first) begin
              r0 = px[k]; r1 = py[k];
              first = 1'b1;
            end else if (r0 != px[k] || r1 != py[k]) begin
              r2 = px[k]; r3 = py[k];
              second = 1'b1;
            end
          end
        end
        f_hit = second;
      end
    end
  end

  // output register; one-cycle strobe per word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= f_valid;
      hit  <= f_valid && f_hit;
    end
    if (f_valid) begin
      clip_x1 <= f_hit ? r0 : '0;
      clip_y1 <= f_hit ? r1 : '0;
      clip_x2 <= f_hit ? r2 : '0;
      clip_y2 <= f_hit ? r3 : '0;
    end
  end

  // every accepted word raises done at the matching edge
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted word produced no result strobe");

  // no strobe without a word accepted at the matching edge
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe out of step with accepted words");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (clip_x1 == '0 && clip_y1 == '0 && clip_x2 == '0 && clip_y2 == '0))
    else $error("miss with nonzero clip endpoints");

  a_hit_strobe: assert property (@(posedge clk) disable iff (rst)
    hit |-> done)
    else $error("hit without result strobe");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire
